@@ src/lfps_pkg.sv @@
//------------------------------------------------------------------------------
// lfps_pkg
// Shared constants, register indexes and controller command types for the
// line follower steering block.
//------------------------------------------------------------------------------
`default_nettype none

package lfps_pkg;

   localparam int NUM_SENSORS_DEF = 8;
   localparam int FULL_SCALE_DEF  = 1000;
   localparam int SAMPLE_BITS_DEF = 10;

   localparam int THR_W      = 10;
   localparam int GAIN_W     = 16;
   localparam int SPEED_W    = 14;
   localparam int OUT_W      = 16;
   localparam int POS_W      = 13;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int GAIN_SHIFT = 12;
   localparam int CNT_W      = 5;

   localparam int DARK_RESET    = 600;
   localparam int BRIGHT_RESET  = 900;
   localparam int ONLINE_RESET  = 200;
   localparam int WEIGHT_RESET  = 50;
   localparam int PROP_RESET    = 3277;
   localparam int INTEG_RESET   = 0;
   localparam int DERIV_RESET   = 82;
   localparam int BASE_RESET    = 1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DARK   = 3'd0,
      REG_BRIGHT = 3'd1,
      REG_ONLINE = 3'd2,
      REG_WEIGHT = 3'd3,
      REG_PROP   = 3'd4,
      REG_INTEG  = 3'd5,
      REG_DERIV  = 3'd6,
      REG_BASE   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic             norm_init;
      logic             norm_step;
      logic             acc_init;
      logic             acc_step;
      logic             div_init;
      logic             div_step;
      logic             pos_calc;
      logic             mul;
      logic             sum;
      logic             pid;
      logic             finish;
      logic [CNT_W-1:0] idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } ctl_sts_type;

endpackage

`default_nettype wire

@@ src/lfps_req_if.sv @@
//------------------------------------------------------------------------------
// lfps_req_if
// Input channel carrying one frame of raw ground sensor readings.
//------------------------------------------------------------------------------
`default_nettype none

interface lfps_req_if #(
   parameter int NUM_SENSORS = lfps_pkg::NUM_SENSORS_DEF,
   parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF
);
   logic                               valid;
   logic                               ready;
   logic [NUM_SENSORS*SAMPLE_BITS-1:0] sensor;

   modport source (output valid, output sensor, input ready);
   modport sink (input valid, input sensor, output ready);
endinterface

`default_nettype wire

@@ src/lfps_rsp_if.sv @@
//------------------------------------------------------------------------------
// lfps_rsp_if
// Result channel carrying wheel commands and the line estimate.
//------------------------------------------------------------------------------
`default_nettype none

interface lfps_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [lfps_pkg::OUT_W-1:0] left_speed;
   logic signed [lfps_pkg::OUT_W-1:0] right_speed;
   logic [lfps_pkg::POS_W-1:0]        line_position;
   logic                              on_line;

   modport source (output valid, output left_speed, output right_speed,
                   output line_position, output on_line, input ready);
   modport sink (input valid, input left_speed, input right_speed,
                 input line_position, input on_line, output ready);
endinterface

`default_nettype wire

@@ src/line_follow_pd_steering.sv @@
// Each frame runs through the bit-serial normalization dividers, the per-sensor
// accumulation, the bit-serial position divider and the position, multiply, sum, PID
// and finish states. A new frame is accepted only once the previous result has been
// written to the output register; that write waits while a stalled result is held.
// Synchronous active-high reset restores the register defaults and clears the last
// position and previous error.
//------------------------------------------------------------------------------
// line_follow_pd_steering
// Line follower steering: sensor normalization, weighted line position and
// PID wheel speed commands.
//------------------------------------------------------------------------------
`default_nettype none

module line_follow_pd_steering #(
   parameter int NUM_SENSORS = lfps_pkg::NUM_SENSORS_DEF,
   parameter int FULL_SCALE  = lfps_pkg::FULL_SCALE_DEF,
   parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   lfps_req_if.sink                      req_ch,
   lfps_rsp_if.source                    rsp_ch,
   input  wire                           csr_wr_en,
   input  wire [lfps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [lfps_pkg::CSR_W-1:0]     csr_wdata
);
   import lfps_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic        accept;
   logic        ready;

   assign req_ch.ready = ready;
   assign accept       = req_ch.valid && ready;

   lfps_ctrl #(
      .NUM_SENSORS(NUM_SENSORS),
      .FULL_SCALE (FULL_SCALE)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_ready(ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   lfps_datapath #(
      .NUM_SENSORS(NUM_SENSORS),
      .FULL_SCALE (FULL_SCALE),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .sensor   (req_ch.sensor),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

@@ src/lfps_ctrl.sv @@
//------------------------------------------------------------------------------
// lfps_ctrl
// Sequencer that steps the datapath through normalization, accumulation,
// position division and the steering arithmetic.
//------------------------------------------------------------------------------
`default_nettype none

module lfps_ctrl #(
   parameter int NUM_SENSORS = lfps_pkg::NUM_SENSORS_DEF,
   parameter int FULL_SCALE  = lfps_pkg::FULL_SCALE_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         accept,
   output logic                        req_ready,
   output lfps_pkg::ctl_cmd_type       cmd,
   input  wire lfps_pkg::ctl_sts_type  sts
);
   import lfps_pkg::*;

   localparam int QB  = $clog2(FULL_SCALE + 1);
   localparam int TOP = FULL_SCALE * (NUM_SENSORS - 1);
   localparam int PW  = $clog2(TOP + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM_INIT, ST_NORM, ST_ACC_INIT, ST_ACC, ST_DIV_INIT, ST_DIV,
      ST_POS, ST_MUL, ST_SUM, ST_PID, ST_FIN
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_NORM_INIT;
                  ready_ff <= 1'b0;
               end
            end
            ST_NORM_INIT: begin
               state_ff <= ST_NORM;
               cnt_ff   <= '0;
            end
            ST_NORM: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(QB - 1)) begin
                  state_ff <= ST_ACC_INIT;
               end
            end
            ST_ACC_INIT: begin
               state_ff <= ST_ACC;
               cnt_ff   <= '0;
            end
            ST_ACC: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(NUM_SENSORS - 1)) begin
                  state_ff <= ST_DIV_INIT;
               end
            end
            ST_DIV_INIT: begin
               state_ff <= ST_DIV;
               cnt_ff   <= '0;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(PW - 1)) begin
                  state_ff <= ST_POS;
               end
            end
            ST_POS: state_ff <= ST_MUL;
            ST_MUL: state_ff <= ST_SUM;
            ST_SUM: state_ff <= ST_PID;
            ST_PID: state_ff <= ST_FIN;
            ST_FIN: begin
               if (!sts.out_busy) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.idx       = cnt_ff;
      cmd.norm_init = (state_ff == ST_NORM_INIT);
      cmd.norm_step = (state_ff == ST_NORM);
      cmd.acc_init  = (state_ff == ST_ACC_INIT);
      cmd.acc_step  = (state_ff == ST_ACC);
      cmd.div_init  = (state_ff == ST_DIV_INIT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.pos_calc  = (state_ff == ST_POS);
      cmd.mul       = (state_ff == ST_MUL);
      cmd.sum       = (state_ff == ST_SUM);
      cmd.pid       = (state_ff == ST_PID);
      cmd.finish    = (state_ff == ST_FIN) && !sts.out_busy;
   end

   assign req_ready = ready_ff;

`ifndef SYNTH
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == ST_IDLE)
      else $error("item accepted while busy");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.out_busy)
      else $error("result written into a full output register");
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.norm_step, cmd.acc_step, cmd.div_step, cmd.finish, accept}))
      else $error("overlapping datapath steps");
   a_ready_back: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_ready)
      else $error("input not reopened after finish");
`endif

endmodule

`default_nettype wire

@@ src/lfps_datapath.sv @@
//------------------------------------------------------------------------------
// lfps_datapath
// Sensor normalization lanes, weighted sums, position divider, PID terms,
// configuration registers and the output register.
//------------------------------------------------------------------------------
`default_nettype none

module lfps_datapath #(
   parameter int NUM_SENSORS = lfps_pkg::NUM_SENSORS_DEF,
   parameter int FULL_SCALE  = lfps_pkg::FULL_SCALE_DEF,
   parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    accept,
   input  wire [NUM_SENSORS*SAMPLE_BITS-1:0]      sensor,
   input  wire                                    csr_wr_en,
   input  wire [lfps_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire [lfps_pkg::CSR_W-1:0]              csr_wdata,
   input  wire lfps_pkg::ctl_cmd_type             cmd,
   output lfps_pkg::ctl_sts_type                  sts,
   lfps_rsp_if.source                             rsp_ch
);
   import lfps_pkg::*;

   localparam int N      = NUM_SENSORS;
   localparam int SB     = SAMPLE_BITS;
   localparam int QB     = $clog2(FULL_SCALE + 1);
   localparam int NW     = SB + QB;
   localparam int TOP    = FULL_SCALE * (N - 1);
   localparam int CENTER = TOP / 2;
   localparam int PW     = $clog2(TOP + 1);
   localparam int EW     = PW + 1;
   localparam int VW     = $clog2(N * FULL_SCALE + 1);
   localparam int XW     = VW + PW;
   localparam int IW     = $clog2(N);
   localparam int MW     = (QB > THR_W) ? QB : THR_W;
   localparam int PRW    = EW + GAIN_W + 2;
   localparam int AW     = PRW + 2;
   localparam int DW     = AW - GAIN_SHIFT;
   localparam int SW     = DW + 1;
   localparam int ROUND  = (1 << GAIN_SHIFT) - 1;
   localparam int SAT_HI = (1 << (OUT_W - 1)) - 1;
   localparam int SAT_LO = -(1 << (OUT_W - 1));

   // Configuration registers.
   logic [SB-1:0]      dark_ff, bright_ff;
   logic [THR_W-1:0]   online_th_ff, weight_th_ff;
   logic [GAIN_W-1:0]  prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [SPEED_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff       <= SB'(DARK_RESET);
         bright_ff     <= SB'(BRIGHT_RESET);
         online_th_ff  <= THR_W'(ONLINE_RESET);
         weight_th_ff  <= THR_W'(WEIGHT_RESET);
         prop_gain_ff  <= GAIN_W'(PROP_RESET);
         integ_gain_ff <= GAIN_W'(INTEG_RESET);
         deriv_gain_ff <= GAIN_W'(DERIV_RESET);
         base_ff       <= SPEED_W'(BASE_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DARK:   dark_ff       <= csr_wdata[SB-1:0];
            REG_BRIGHT: bright_ff     <= csr_wdata[SB-1:0];
            REG_ONLINE: online_th_ff  <= csr_wdata[THR_W-1:0];
            REG_WEIGHT: weight_th_ff  <= csr_wdata[THR_W-1:0];
            REG_PROP:   prop_gain_ff  <= csr_wdata[GAIN_W-1:0];
            REG_INTEG:  integ_gain_ff <= csr_wdata[GAIN_W-1:0];
            REG_DERIV:  deriv_gain_ff <= csr_wdata[GAIN_W-1:0];
            REG_BASE:   base_ff       <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // Normalization lanes: one restoring divider per sensor sharing the divisor.
   logic [SB-1:0] smp_ff    [N];
   logic [NW-1:0] lane_num_ff [N];
   logic [QB-1:0] lane_q_ff [N];
   logic          lane_zero_ff [N];
   logic          lane_full_ff [N];
   logic [NW-1:0] dsr_ff;
   logic [QB-1:0] lane_v    [N];
   logic [SB-1:0] span;
   logic          span_ok;

   assign span_ok = bright_ff > dark_ff;
   assign span    = bright_ff - dark_ff;

   always_ff @(posedge clock) begin
      if (cmd.norm_init) begin
         dsr_ff <= NW'(span) << (QB - 1);
      end else if (cmd.norm_step) begin
         dsr_ff <= dsr_ff >> 1;
      end
      for (int i = 0; i < N; i++) begin
         if (accept) begin
            smp_ff[i] <= sensor[i*SB +: SB];
         end
         if (cmd.norm_init) begin
            lane_zero_ff[i] <= !span_ok || (smp_ff[i] <= dark_ff);
            lane_full_ff[i] <= (smp_ff[i] - dark_ff) >= span;
            lane_num_ff[i]  <= NW'(smp_ff[i] - dark_ff) * NW'(FULL_SCALE);
            lane_q_ff[i]    <= '0;
         end else if (cmd.norm_step) begin
            if (lane_num_ff[i] >= dsr_ff) begin
               lane_num_ff[i] <= lane_num_ff[i] - dsr_ff;
               lane_q_ff[i]   <= {lane_q_ff[i][QB-2:0], 1'b1};
            end else begin
               lane_q_ff[i]   <= {lane_q_ff[i][QB-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (lane_zero_ff[i]) begin
            lane_v[i] = '0;
         end else if (lane_full_ff[i]) begin
            lane_v[i] = QB'(FULL_SCALE);
         end else begin
            lane_v[i] = lane_q_ff[i];
         end
      end
   end

   // Weighted accumulation, one sensor per cycle.
   logic [QB-1:0] sel_v;
   logic [VW-1:0] vsum_ff;
   logic [XW-1:0] wsum_ff;
   logic [PW-1:0] weight_ff;
   logic          online_ff;

   assign sel_v = lane_v[cmd.idx[IW-1:0]];

   always_ff @(posedge clock) begin
      if (cmd.acc_init) begin
         vsum_ff   <= '0;
         wsum_ff   <= '0;
         weight_ff <= '0;
         online_ff <= 1'b0;
      end else if (cmd.acc_step) begin
         weight_ff <= weight_ff + PW'(FULL_SCALE);
         if (MW'(sel_v) > MW'(online_th_ff)) begin
            online_ff <= 1'b1;
         end
         if (MW'(sel_v) > MW'(weight_th_ff)) begin
            vsum_ff <= vsum_ff + VW'(sel_v);
            wsum_ff <= wsum_ff + XW'(sel_v) * XW'(weight_ff);
         end
      end
   end

   // Position divider: quotient known to stay below 2**PW.
   logic [XW-1:0] rem_ff, dvs_ff;
   logic [PW-1:0] pq_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= wsum_ff;
         dvs_ff <= XW'(vsum_ff) << (PW - 1);
         pq_ff  <= '0;
      end else if (cmd.div_step) begin
         dvs_ff <= dvs_ff >> 1;
         if (rem_ff >= dvs_ff) begin
            rem_ff <= rem_ff - dvs_ff;
            pq_ff  <= {pq_ff[PW-2:0], 1'b1};
         end else begin
            pq_ff  <= {pq_ff[PW-2:0], 1'b0};
         end
      end
   end

   // Position, error and PID arithmetic.
   logic [PW-1:0]        last_pos_ff, pos_ff, pos_sel;
   logic signed [EW-1:0] prev_err_ff, err_ff, err_in;
   logic signed [EW:0]   esum_ff, edif_ff;
   logic signed [PRW-1:0] prod_p_ff, prod_i_ff, prod_d_ff;
   logic signed [AW-1:0] acc_ff, acc_biased;
   logic signed [DW-1:0] pid_ff;
   logic signed [SW-1:0] left_sum, right_sum, base_s;

   always_comb begin
      if (online_ff) begin
         pos_sel = (vsum_ff != '0) ? pq_ff : last_pos_ff;
      end else begin
         pos_sel = (last_pos_ff < PW'(CENTER)) ? '0 : PW'(TOP);
      end
   end

   assign err_in     = $signed({1'b0, pos_sel}) - $signed(EW'(CENTER));
   assign acc_biased = acc_ff + ((acc_ff < 0) ? AW'(ROUND) : AW'(0));
   assign base_s     = $signed(SW'(base_ff));
   assign left_sum   = base_s + SW'(pid_ff);
   assign right_sum  = base_s - SW'(pid_ff);

   function automatic logic signed [OUT_W-1:0] sat16(input logic signed [SW-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > $signed(SW'(SAT_HI))) begin
         r = OUT_W'(SAT_HI);
      end else if (v < $signed(SW'(SAT_LO))) begin
         r = OUT_W'(SAT_LO);
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.pos_calc) begin
         pos_ff  <= pos_sel;
         err_ff  <= err_in;
         esum_ff <= (EW + 1)'(err_in) + (EW + 1)'(prev_err_ff);
         edif_ff <= (EW + 1)'(err_in) - (EW + 1)'(prev_err_ff);
      end
      if (cmd.mul) begin
         prod_p_ff <= PRW'($signed({1'b0, prop_gain_ff})) * PRW'(err_ff);
         prod_i_ff <= PRW'($signed({1'b0, integ_gain_ff})) * PRW'(esum_ff);
         prod_d_ff <= PRW'($signed({1'b0, deriv_gain_ff})) * PRW'(edif_ff);
      end
      if (cmd.sum) begin
         acc_ff <= AW'(prod_p_ff) + AW'(prod_i_ff) + AW'(prod_d_ff);
      end
      if (cmd.pid) begin
         pid_ff <= acc_biased[AW-1:GAIN_SHIFT];
      end
   end

   // Loop state and output register.
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] left_ff, right_ff;
   logic [PW-1:0]           out_pos_ff;
   logic                    out_online_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff  <= '0;
         prev_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         last_pos_ff  <= pos_ff;
         prev_err_ff  <= err_ff;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_pos_ff    <= pos_ff;
         out_online_ff <= online_ff;
         if (online_ff) begin
            left_ff  <= sat16(left_sum);
            right_ff <= sat16(right_sum);
         end else if (pos_ff == '0) begin
            left_ff  <= -$signed({2'b00, base_ff});
            right_ff <= $signed({2'b00, base_ff});
         end else begin
            left_ff  <= $signed({2'b00, base_ff});
            right_ff <= -$signed({2'b00, base_ff});
         end
      end
   end

   assign sts.out_busy         = rsp_valid_ff && !rsp_ch.ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.left_speed    = left_ff;
   assign rsp_ch.right_speed   = right_ff;
   assign rsp_ch.line_position = POS_W'(out_pos_ff);
   assign rsp_ch.on_line       = out_online_ff;

`ifndef SYNTH
   a_valid_after_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("result not presented after finish");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> out_pos_ff <= PW'(TOP))
      else $error("line position out of range");
   a_lost_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_online_ff) |-> (out_pos_ff == '0 || out_pos_ff == PW'(TOP)))
      else $error("lost line position not at an edge");
`endif

endmodule

`default_nettype wire
